// ----- rtl/btc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btc_pkg: shared definitions for the block transposition cipher
// Widths, register codes, reset values, controller state, command and status
// structures, and the key entry decode.
// ----------------------------------------------------------------------------
package btc_pkg;

    // Field and register widths
    localparam int CHAR_W       = 8;
    localparam int BS_W         = 4;
    localparam int KEY_W        = 24;
    localparam int KEY_ENT_W    = 3;
    localparam int KEY_ENTRIES  = 8;
    localparam int SRC_W        = 4;    // holds a source position up to 15
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 24;

    // Default and limit of the block depth
    localparam int MAX_BLOCK_DEF = 8;

    // Register reset values
    localparam logic [BS_W-1:0]  BLOCK_SIZE_RST = 4'd8;
    localparam logic [KEY_W-1:0] PERM_KEY_RST   = 24'd16434824;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_SIZE = 1'b0,
        CFG_PERM_KEY   = 1'b1
    } t_cfg_reg;

    // Controller states
    typedef enum logic {
        ST_ACCEPT = 1'b0,
        ST_EMIT   = 1'b1
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;  // input transaction taken this cycle
        logic load;     // load next result into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic will_emit;  // the character on the input would close a block
        logic out_free;   // output register can take a new result
        logic idx_final;  // current result index is the last of the block
    } t_dp_status;

    // Source position for output position i: key entries past the eighth
    // are taken as identity
    function automatic logic [SRC_W-1:0] key_src(input logic [KEY_W-1:0] key,
                                                 input logic [SRC_W-1:0] i);
        logic [SRC_W-1:0] res;
        res = i;
        if (i < SRC_W'(KEY_ENTRIES)) begin
            case (i[KEY_ENT_W-1:0])
                3'd0:    res = {1'b0, key[2:0]};
                3'd1:    res = {1'b0, key[5:3]};
                3'd2:    res = {1'b0, key[8:6]};
                3'd3:    res = {1'b0, key[11:9]};
                3'd4:    res = {1'b0, key[14:12]};
                3'd5:    res = {1'b0, key[17:15]};
                3'd6:    res = {1'b0, key[20:18]};
                3'd7:    res = {1'b0, key[23:21]};
                default: res = i;
            endcase
        end
        return res;
    endfunction

endpackage

// ----- rtl/btc_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btc_in_if: character input channel
// Valid/ready handshake carrying one message character and its last flag.
// ----------------------------------------------------------------------------
interface btc_in_if;
    logic                        valid;
    logic                        ready;
    logic [btc_pkg::CHAR_W-1:0]  in_char;
    logic                        in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

// ----- rtl/btc_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btc_out_if: character output channel
// Valid/ready handshake carrying one result character, last and fault flags.
// ----------------------------------------------------------------------------
interface btc_out_if;
    logic                        valid;
    logic                        ready;
    logic [btc_pkg::CHAR_W-1:0]  out_char;
    logic                        out_last;
    logic                        key_fault;

    modport source (output valid, output out_char, output out_last,
                    output key_fault, input ready);
    modport sink   (input valid, input out_char, input out_last,
                    input key_fault, output ready);
endinterface

// ----- rtl/btc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btc_ctrl: cipher controller
// Alternates between taking characters and streaming out a finished block.
// ----------------------------------------------------------------------------
module btc_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  btc_pkg::t_dp_status    i_status,
    output btc_pkg::t_dp_cmd       o_cmd
);

    btc_pkg::t_state r_state;
    btc_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btc_pkg::ST_ACCEPT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            btc_pkg::ST_ACCEPT: begin
                if (i_in_valid && i_status.will_emit) begin
                    n_state = btc_pkg::ST_EMIT;
                end
            end
            btc_pkg::ST_EMIT: begin
                if (i_status.out_free && i_status.idx_final) begin
                    n_state = btc_pkg::ST_ACCEPT;
                end
            end
            default: n_state = btc_pkg::ST_ACCEPT;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            btc_pkg::ST_ACCEPT: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            btc_pkg::ST_EMIT: begin
                o_cmd.load = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/btc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btc_datapath: cipher datapath
// Configuration registers, block buffer, fill and result counters, and the
// output register with its permutation select.
// ----------------------------------------------------------------------------
module btc_datapath #(
    parameter int MAX_BLOCK = btc_pkg::MAX_BLOCK_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [btc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [btc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input payload
    input  logic [btc_pkg::CHAR_W-1:0]        i_in_char,
    input  logic                              i_in_last,
    // output channel
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [btc_pkg::CHAR_W-1:0]        o_out_char,
    output logic                              o_out_last,
    output logic                              o_key_fault,
    // controller link
    input  btc_pkg::t_dp_cmd                  i_cmd,
    output btc_pkg::t_dp_status               o_status
);

    localparam int CNT_W = $clog2(MAX_BLOCK + 1);
    localparam int IDX_W = $clog2(MAX_BLOCK);
    localparam int CMP_W = (CNT_W > btc_pkg::SRC_W) ? CNT_W : btc_pkg::SRC_W;

    // Configuration registers
    logic [btc_pkg::BS_W-1:0]   r_block_size;
    logic [btc_pkg::KEY_W-1:0]  r_perm_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= btc_pkg::BLOCK_SIZE_RST;
            r_perm_key   <= btc_pkg::PERM_KEY_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == btc_pkg::CFG_BLOCK_SIZE) begin
                r_block_size <= i_cfg_data[btc_pkg::BS_W-1:0];
            end
            if (i_cfg_idx == btc_pkg::CFG_PERM_KEY) begin
                r_perm_key <= i_cfg_data[btc_pkg::KEY_W-1:0];
            end
        end
    end

    // Effective block size: zero means one, saturate at the buffer depth
    logic [CMP_W-1:0] bs_ext;
    logic [CMP_W-1:0] bs_eff;

    always_comb begin
        bs_ext = CMP_W'(r_block_size);
        if (bs_ext == '0) begin
            bs_eff = CMP_W'(1);
        end else if (bs_ext > CMP_W'(MAX_BLOCK)) begin
            bs_eff = CMP_W'(MAX_BLOCK);
        end else begin
            bs_eff = bs_ext;
        end
    end

    // Fill tracking on the incoming character
    logic [CNT_W-1:0]  r_fill;
    logic              fill_room;
    logic [CNT_W-1:0]  fill_next;
    logic              blk_full;

    assign fill_room = (r_fill < CNT_W'(MAX_BLOCK));
    assign fill_next = fill_room ? (r_fill + CNT_W'(1)) : r_fill;
    assign blk_full  = (CMP_W'(fill_next) >= bs_eff);

    // Block buffer, no reset: every read entry was written in this block
    logic [btc_pkg::CHAR_W-1:0] r_store [MAX_BLOCK];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture && fill_room) begin
            r_store[r_fill[IDX_W-1:0]] <= i_in_char;
        end
    end

    // Emission control registers
    logic              r_perm;    // permuted block, else in-order flush
    logic              r_last;
    logic [CNT_W-1:0]  r_count;   // results in this emission
    logic [CNT_W-1:0]  r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_perm  <= 1'b0;
            r_last  <= 1'b0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.capture) begin
                if (blk_full || i_in_last) begin
                    r_fill  <= '0;
                    r_perm  <= blk_full;
                    r_last  <= i_in_last;
                    r_count <= blk_full ? bs_eff[CNT_W-1:0] : fill_next;
                    r_idx   <= '0;
                end else begin
                    r_fill <= fill_next;
                end
            end
            if (i_cmd.load) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    // Source selection for the current result
    logic [btc_pkg::SRC_W-1:0]  src;
    logic                       fault;
    logic [IDX_W-1:0]           rd_addr;
    logic [btc_pkg::CHAR_W-1:0] rd_char;
    logic                       idx_final;

    assign src       = btc_pkg::key_src(r_perm_key, btc_pkg::SRC_W'(r_idx));
    assign fault     = r_perm && (CMP_W'(src) >= CMP_W'(r_count));
    assign rd_addr   = r_perm ? src[IDX_W-1:0] : r_idx[IDX_W-1:0];
    assign rd_char   = fault ? '0 : r_store[rd_addr];
    assign idx_final = (r_idx == (r_count - CNT_W'(1)));

    // Output register
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic [btc_pkg::CHAR_W-1:0]  r_out_char;
    logic                        r_out_last;
    logic                        r_key_fault;

    always_comb begin
        if (i_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_char  <= rd_char;
            r_out_last  <= r_last && idx_final;
            r_key_fault <= fault;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;
    assign o_key_fault = r_key_fault;

    // Status to controller
    assign o_status.will_emit = blk_full || i_in_last;
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.idx_final = idx_final;

endmodule

// ----- rtl/block_transposition_cipher_core.sv -----
`timescale 1ns / 1ps
// The character that closes a block moves the controller into its emit state;
// results are then loaded into the output register one a cycle while it is free.
// No character is taken while the block buffer is being read out.
// Reset (synchronous, active low) empties the buffer and restores the registers.
// ----------------------------------------------------------------------------
// block_transposition_cipher_core: block transposition cipher
// Gathers characters into blocks and emits each full block in key order, or a
// final partial block in arrival order.
// ----------------------------------------------------------------------------
module block_transposition_cipher_core #(
    parameter int MAX_BLOCK = btc_pkg::MAX_BLOCK_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [btc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [btc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    btc_in_if.sink                          i_in,
    btc_out_if.source                       o_out
);

    btc_pkg::t_dp_cmd     cmd;
    btc_pkg::t_dp_status  status;
    logic                 in_ready;

    // Controller
    btc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // Datapath
    btc_datapath #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_char   (i_in.in_char),
        .i_in_last   (i_in.in_last),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_char  (o_out.out_char),
        .o_out_last  (o_out.out_last),
        .o_key_fault (o_out.key_fault),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule
